FILE: rtl/core/rcsp_pkg.sv
// Package for the raycaster sprite projection core.
// Holds sizes, register indexes and the payload types of every channel.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcsp_pkg;

   localparam int MAX_SPRITES = 32;
   localparam int IDX_W       = 5;
   localparam int CNT_W       = 6;
   localparam int CSR_IDX_W   = 3;
   localparam int DIV_NW      = 56;
   localparam int DIV_DW      = 33;

   localparam logic [CSR_IDX_W-1:0] CSR_CAM_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCR_W   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SCR_H   = 3'd7;

   typedef struct packed {
      logic [5:0] cell_row;
      logic [5:0] cell_col;
      logic       cell_valid;
      logic       frame_last;
   } req_payload_type;

   typedef struct packed {
      logic [IDX_W-1:0]   sprite_index;
      logic [IDX_W-1:0]   rank;
      logic signed [31:0] depth;
      logic signed [15:0] screen_x;
      logic [15:0]        sprite_size;
      logic [10:0]        draw_start_y;
      logic [10:0]        draw_end_y;
      logic [14:0]        draw_start_x;
      logic signed [15:0] draw_end_x;
      logic               not_drawable;
      logic               last;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] reg_index;
      logic [15:0]          wr_data;
   } csr_payload_type;

endpackage

`default_nettype wire

FILE: rtl/core/rcsp_if.sv
// Channel interfaces for the raycaster sprite projection core.
// Depends on rcsp_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface rcsp_req_if import rcsp_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rcsp_rsp_if import rcsp_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rcsp_csr_if import rcsp_pkg::*; ();
   logic            valid;
   logic            ready;
   csr_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/raycaster_sprite_projection_core.sv
// Raycaster sprite projection core: sprite load, far-to-near sort, projection.
// Depends on rcsp_pkg and the channel interfaces in rcsp_if.
//
//   channel  dir  beat
//   req_if   in   one cell or end marker; frame_last starts the frame pass if a sprite is held
//   rsp_if   out  one projected sprite, far to near, last on the final one
//   csr_if   in   register index and 16 bit data, always ready
//
// A frame pass first runs the insertion sort, one sprite at a time, and then
// projects each sprite in turn, with up to three 56-step passes of the shared
// radix-2 divider.
// req_if is ready only while idle; one result is held until rsp_if takes it.
// Reset is synchronous and clears the control state and registers only.
`timescale 1ns / 1ps
`default_nettype none

module raycaster_sprite_projection_core import rcsp_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   rcsp_req_if.sink    req_if,
   rcsp_rsp_if.source  rsp_if,
   rcsp_csr_if.sink    csr_if
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_SLD, ST_SQ1, ST_SQ2, ST_SQ3, ST_INS,
      ST_PLD, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
      ST_DDIV, ST_DCHK, ST_SXM, ST_XDIV, ST_XCHK, ST_ZDIV, ST_BND, ST_OUT
   } state_type;

   state_type state_ff;

   logic [15:0]        cam_x_ff, cam_y_ff;
   logic signed [15:0] dir_x_ff, dir_y_ff, pl_x_ff, pl_y_ff;
   logic [11:0]        scr_w_ff, scr_h_ff;

   logic [5:0]  row_mem_ff  [MAX_SPRITES];
   logic [5:0]  col_mem_ff  [MAX_SPRITES];
   logic [IDX_W-1:0] ord_mem_ff [MAX_SPRITES];
   logic [31:0] dist_mem_ff [MAX_SPRITES];

   logic [CNT_W-1:0] cnt_ff;
   logic [IDX_W-1:0] i_ff, j_ff, r_ff, idx_ff;

   logic signed [17:0] dx_ff, dy_ff;
   logic signed [52:0] prod_ff, t_ff;
   logic [31:0]        kd_ff;
   logic signed [33:0] numx_ff, numy_ff;
   logic [30:0]        depth_ff;
   logic signed [47:0] sx_ff;

   logic [DIV_NW-1:0] div_num_ff;
   logic [DIV_DW-1:0] div_den_ff;
   logic [DIV_DW:0]   div_rem_ff;
   logic              div_neg_ff;
   logic [5:0]        div_cnt_ff;

   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff;

   // datapath wires
   logic [CNT_W-1:0]   cnt_in;
   logic               cell_add;
   logic [IDX_W-1:0]   sel_idx, jm1;
   logic [17:0]        px, py;
   logic signed [17:0] dx_sel, dy_sel;
   logic signed [34:0] mul_a;
   logic signed [17:0] mul_b;
   logic signed [52:0] prod_in, det_w, det_mag, numy_mag, prod_mag, sq_sum;
   logic [DIV_DW:0]    rem_sh, div_rem_in;
   logic               div_ge;
   logic [DIV_NW-1:0]  div_num_in;
   logic signed [56:0] div_q;
   logic               is_last;
   logic [27:0]        size_w;
   logic signed [47:0] hs_s, h2_s, h_s, w_s, dsy_s, dey_s, dey_c, dsx_s, dex_s, dex_c;
   rsp_payload_type    nd_pl, bnd_pl;

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   assign cell_add = req_if.payload.cell_valid && (cnt_ff < CNT_W'(MAX_SPRITES));
   assign cnt_in   = cnt_ff + CNT_W'(cell_add);
   assign is_last  = ({1'b0, r_ff} == (cnt_ff - CNT_W'(1)));
   assign jm1      = j_ff - IDX_W'(1);

   assign sel_idx = (state_ff == ST_SLD) ? i_ff : ord_mem_ff[r_ff];
   assign px      = {2'b00, col_mem_ff[sel_idx], 10'd512};
   assign py      = {2'b00, row_mem_ff[sel_idx], 10'd512};
   assign dx_sel  = $signed(px - {2'b00, cam_x_ff});
   assign dy_sel  = $signed(py - {2'b00, cam_y_ff});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQ1: begin mul_a = 35'(dx_ff);    mul_b = dx_ff; end
         ST_SQ2: begin mul_a = 35'(dy_ff);    mul_b = dy_ff; end
         ST_P1:  begin mul_a = 35'(dir_y_ff); mul_b = dx_ff; end
         ST_P2:  begin mul_a = 35'(dir_x_ff); mul_b = dy_ff; end
         ST_P3:  begin mul_a = 35'(pl_x_ff);  mul_b = dy_ff; end
         ST_P4:  begin mul_a = 35'(pl_y_ff);  mul_b = dx_ff; end
         ST_P5:  begin mul_a = 35'(pl_x_ff);  mul_b = 18'(dir_y_ff); end
         ST_P6:  begin mul_a = 35'(dir_x_ff); mul_b = 18'(pl_y_ff); end
         ST_DCHK: begin
            mul_a = 35'(numy_ff) + 35'(numx_ff);
            mul_b = $signed({7'b0, scr_w_ff[11:1]});
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in  = 53'(mul_a) * 53'(mul_b);
   assign sq_sum   = t_ff + prod_ff;
   assign det_w    = t_ff - prod_ff;
   assign det_mag  = det_w[52] ? -det_w : det_w;
   assign numy_mag = numy_ff[33] ? -53'(numy_ff) : 53'(numy_ff);
   assign prod_mag = prod_ff[52] ? -prod_ff : prod_ff;

   assign rem_sh     = {div_rem_ff[DIV_DW-1:0], div_num_ff[DIV_NW-1]};
   assign div_ge     = (rem_sh >= {1'b0, div_den_ff});
   assign div_rem_in = div_ge ? (rem_sh - {1'b0, div_den_ff}) : rem_sh;
   assign div_num_in = {div_num_ff[DIV_NW-2:0], div_ge};
   assign div_q      = div_neg_ff ? -$signed({1'b0, div_num_ff}) : $signed({1'b0, div_num_ff});

   always_comb begin
      nd_pl              = '0;
      nd_pl.sprite_index = idx_ff;
      nd_pl.rank         = r_ff;
      nd_pl.not_drawable = 1'b1;
      nd_pl.last         = is_last;
   end

   always_comb begin
      size_w = div_num_ff[27:0];
      hs_s   = $signed(48'(size_w[27:1]));
      h2_s   = $signed(48'(scr_h_ff[11:1]));
      h_s    = $signed(48'(scr_h_ff));
      w_s    = $signed(48'(scr_w_ff));
      dsy_s  = h2_s - hs_s;
      dey_s  = hs_s + h2_s;
      dsx_s  = sx_ff - hs_s;
      dex_s  = hs_s + sx_ff;
      if (dey_s >= h_s) begin
         dey_c = (scr_h_ff != 12'd0) ? (h_s - 48'sd1) : 48'sd0;
      end else begin
         dey_c = dey_s;
      end
      if (dex_s >= w_s) begin
         dex_c = w_s - 48'sd1;
      end else begin
         dex_c = dex_s;
      end
      bnd_pl              = '0;
      bnd_pl.sprite_index = idx_ff;
      bnd_pl.rank         = r_ff;
      bnd_pl.last         = is_last;
      bnd_pl.depth        = $signed({1'b0, depth_ff});
      if (sx_ff > 48'sd32767) begin
         bnd_pl.screen_x = 16'sd32767;
      end else if (sx_ff < -48'sd32768) begin
         bnd_pl.screen_x = -16'sd32768;
      end else begin
         bnd_pl.screen_x = sx_ff[15:0];
      end
      bnd_pl.sprite_size  = (size_w > 28'd65535) ? 16'hFFFF : size_w[15:0];
      bnd_pl.draw_start_y = (dsy_s < 48'sd0) ? 11'd0 : dsy_s[10:0];
      bnd_pl.draw_end_y   = (dey_c > 48'sd2047) ? 11'd2047 : dey_c[10:0];
      if (dsx_s < 48'sd0) begin
         bnd_pl.draw_start_x = 15'd0;
      end else if (dsx_s > 48'sd32767) begin
         bnd_pl.draw_start_x = 15'd32767;
      end else begin
         bnd_pl.draw_start_x = dsx_s[14:0];
      end
      if (dex_c > 48'sd32767) begin
         bnd_pl.draw_end_x = 16'sd32767;
      end else if (dex_c < -48'sd32768) begin
         bnd_pl.draw_end_x = -16'sd32768;
      end else begin
         bnd_pl.draw_end_x = dex_c[15:0];
      end
      bnd_pl.not_drawable = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cam_x_ff     <= 16'd0;
         cam_y_ff     <= 16'd0;
         dir_x_ff     <= 16'sd16384;
         dir_y_ff     <= 16'sd0;
         pl_x_ff      <= 16'sd0;
         pl_y_ff      <= 16'sd10813;
         scr_w_ff     <= 12'd640;
         scr_h_ff     <= 12'd480;
      end else begin
         prod_ff <= prod_in;
         if (csr_if.valid) begin
            unique case (csr_if.payload.reg_index)
               CSR_CAM_X:   cam_x_ff <= csr_if.payload.wr_data;
               CSR_CAM_Y:   cam_y_ff <= csr_if.payload.wr_data;
               CSR_DIR_X:   dir_x_ff <= $signed(csr_if.payload.wr_data);
               CSR_DIR_Y:   dir_y_ff <= $signed(csr_if.payload.wr_data);
               CSR_PLANE_X: pl_x_ff  <= $signed(csr_if.payload.wr_data);
               CSR_PLANE_Y: pl_y_ff  <= $signed(csr_if.payload.wr_data);
               CSR_SCR_W:   scr_w_ff <= csr_if.payload.wr_data[11:0];
               CSR_SCR_H:   scr_h_ff <= csr_if.payload.wr_data[11:0];
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  if (cell_add) begin
                     row_mem_ff[cnt_ff[IDX_W-1:0]] <= req_if.payload.cell_row;
                     col_mem_ff[cnt_ff[IDX_W-1:0]] <= req_if.payload.cell_col;
                  end
                  cnt_ff <= cnt_in;
                  i_ff   <= '0;
                  if (req_if.payload.frame_last && (cnt_in != '0)) begin
                     state_ff <= ST_SLD;
                  end
               end
            end
            ST_SLD: begin
               dx_ff    <= dx_sel;
               dy_ff    <= dy_sel;
               j_ff     <= i_ff;
               state_ff <= ST_SQ1;
            end
            ST_SQ1: state_ff <= ST_SQ2;
            ST_SQ2: begin
               t_ff     <= prod_ff;
               state_ff <= ST_SQ3;
            end
            ST_SQ3: begin
               kd_ff    <= sq_sum[33:2];
               state_ff <= ST_INS;
            end
            ST_INS: begin
               if ((j_ff != '0) && (dist_mem_ff[jm1] < kd_ff)) begin
                  dist_mem_ff[j_ff] <= dist_mem_ff[jm1];
                  ord_mem_ff[j_ff]  <= ord_mem_ff[jm1];
                  j_ff              <= jm1;
               end else begin
                  dist_mem_ff[j_ff] <= kd_ff;
                  ord_mem_ff[j_ff]  <= i_ff;
                  if ({1'b0, i_ff} == (cnt_ff - CNT_W'(1))) begin
                     r_ff     <= '0;
                     state_ff <= ST_PLD;
                  end else begin
                     i_ff     <= i_ff + IDX_W'(1);
                     state_ff <= ST_SLD;
                  end
               end
            end
            ST_PLD: begin
               idx_ff   <= sel_idx;
               dx_ff    <= dx_sel;
               dy_ff    <= dy_sel;
               state_ff <= ST_P1;
            end
            ST_P1: state_ff <= ST_P2;
            ST_P2: begin
               t_ff     <= prod_ff;
               state_ff <= ST_P3;
            end
            ST_P3: begin
               numx_ff  <= det_w[33:0];
               state_ff <= ST_P4;
            end
            ST_P4: begin
               t_ff     <= prod_ff;
               state_ff <= ST_P5;
            end
            ST_P5: begin
               numy_ff  <= det_w[33:0];
               state_ff <= ST_P6;
            end
            ST_P6: begin
               t_ff     <= prod_ff;
               state_ff <= ST_P7;
            end
            ST_P7: begin
               if (det_w == '0) begin
                  rsp_ff       <= nd_pl;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end else begin
                  div_num_ff <= {3'b000, numy_mag[32:0], 20'd0};
                  div_den_ff <= det_mag[DIV_DW-1:0];
                  div_neg_ff <= numy_ff[33] ^ det_w[52];
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= ST_DDIV;
               end
            end
            ST_DDIV, ST_XDIV, ST_ZDIV: begin
               div_num_ff <= div_num_in;
               div_rem_ff <= div_rem_in;
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == 6'(DIV_NW - 1)) begin
                  priority case (state_ff)
                     ST_DDIV: state_ff <= ST_DCHK;
                     ST_XDIV: state_ff <= ST_XCHK;
                     default: state_ff <= ST_BND;
                  endcase
               end
            end
            ST_DCHK: begin
               if (div_q <= 57'sd0) begin
                  rsp_ff       <= nd_pl;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_OUT;
               end else begin
                  depth_ff <= (div_q > 57'sd2147483647) ? 31'h7FFF_FFFF : div_q[30:0];
                  state_ff <= ST_SXM;
               end
            end
            ST_SXM: begin
               div_num_ff <= {3'b000, prod_mag};
               div_den_ff <= numy_mag[DIV_DW-1:0];
               div_neg_ff <= prod_ff[52] ^ numy_ff[33];
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
               state_ff   <= ST_XDIV;
            end
            ST_XCHK: begin
               sx_ff      <= div_q[47:0];
               div_num_ff <= {28'd0, scr_h_ff, 16'd0};
               div_den_ff <= {2'b00, depth_ff};
               div_neg_ff <= 1'b0;
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
               state_ff   <= ST_ZDIV;
            end
            ST_BND: begin
               rsp_ff       <= bnd_pl;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_if.ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (is_last) begin
                     cnt_ff   <= '0;
                     state_ff <= ST_IDLE;
                  end else begin
                     r_ff     <= r_ff + IDX_W'(1);
                     state_ff <= ST_PLD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> state_ff == ST_OUT)
      else $error("result valid outside output state");

   a_nd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.payload.not_drawable |->
         rsp_if.payload.depth == 32'sd0 && rsp_if.payload.sprite_size == 16'd0)
      else $error("not drawable result carries nonzero fields");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_SPRITES))
      else $error("sprite count beyond capacity");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && rsp_if.payload.last |=>
         state_ff == ST_IDLE && cnt_ff == '0)
      else $error("frame did not close after last beat");

endmodule

`default_nettype wire

FILE: sim/rcsp_sprite_checker.sv
// Checker for the raycaster sprite projection core: watches the cell, result and
// register channels, predicts each frame's projected sprites and compares them.
// Depends on rcsp_pkg and the channel interfaces in rcsp_if.
`timescale 1ns / 1ps

module rcsp_sprite_checker import rcsp_pkg::*; (
   input  wire  clock,
   input  wire  reset,
   rcsp_req_if  req_mon,
   rcsp_rsp_if  rsp_mon,
   rcsp_csr_if  csr_mon,
   output int   fail_count,
   output int   pending,
   output int   results_seen
);

   logic [15:0] cam_x, cam_y, dir_x, dir_y, plane_x, plane_y;
   logic [11:0] scr_w, scr_h;
   logic [5:0]  cell_rows [MAX_SPRITES];
   logic [5:0]  cell_cols [MAX_SPRITES];
   int          loaded;
   rsp_payload_type projected_q [$];

   function automatic longint sat(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint offset_x(input int idx);
      return longint'(cell_cols[idx]) * 1024 + 512 - longint'(cam_x);
   endfunction

   function automatic longint offset_y(input int idx);
      return longint'(cell_rows[idx]) * 1024 + 512 - longint'(cam_y);
   endfunction

   function automatic rsp_payload_type project_sprite(input int idx, input int rnk,
                                                      input bit is_last);
      rsp_payload_type r;
      longint dx, dy, dirx, diry, plx, ply, det, w, h;
      longint numx, numy, depth, sx, size, dsy, dey, dsx, dex;
      dx   = offset_x(idx);
      dy   = offset_y(idx);
      dirx = longint'($signed(dir_x));
      diry = longint'($signed(dir_y));
      plx  = longint'($signed(plane_x));
      ply  = longint'($signed(plane_y));
      det  = plx * diry - dirx * ply;
      w    = longint'(scr_w);
      h    = longint'(scr_h);
      r = '0;
      r.sprite_index = idx[IDX_W-1:0];
      r.rank         = rnk[IDX_W-1:0];
      r.last         = is_last;
      numx  = diry * dx - dirx * dy;
      numy  = plx * dy - ply * dx;
      depth = 0;
      if (det != 0) depth = (numy * 1048576) / det;
      if (det == 0 || depth <= 0) begin
         r.not_drawable = 1'b1;
         return r;
      end
      depth = sat(depth, 0, 2147483647);
      sx    = ((w / 2) * (numy + numx)) / numy;
      size  = (h * 65536) / depth;
      dsy = h / 2 - size / 2;
      if (dsy < 0) dsy = 0;
      dey = size / 2 + h / 2;
      if (dey >= h) dey = h > 0 ? h - 1 : 0;
      dsx = sx - size / 2;
      if (dsx < 0) dsx = 0;
      dex = size / 2 + sx;
      if (dex >= w) dex = w - 1;
      r.depth        = depth[31:0];
      r.screen_x     = 16'(sat(sx, -32768, 32767));
      r.sprite_size  = 16'(sat(size, 0, 65535));
      r.draw_start_y = 11'(sat(dsy, 0, 2047));
      r.draw_end_y   = 11'(sat(dey, 0, 2047));
      r.draw_start_x = 15'(sat(dsx, 0, 32767));
      r.draw_end_x   = 16'(sat(dex, -32768, 32767));
      return r;
   endfunction

   task automatic project_frame();
      logic [4:0]  order [MAX_SPRITES];
      logic [31:0] sq_dist [MAX_SPRITES];
      logic [31:0] kd;
      longint      dx, dy;
      int          j;
      for (int i = 0; i < loaded; i++) begin
         dx = offset_x(i);
         dy = offset_y(i);
         kd = 32'((dx * dx + dy * dy) >> 2);
         j  = i;
         while (j > 0 && sq_dist[j-1] < kd) begin
            sq_dist[j] = sq_dist[j-1];
            order[j]   = order[j-1];
            j--;
         end
         sq_dist[j] = kd;
         order[j]   = i[4:0];
      end
      for (int i = 0; i < loaded; i++)
         projected_q.push_back(project_sprite(order[i], i, i + 1 == loaded));
      loaded = 0;
   endtask

   task automatic check_field(input string name, input longint e, input longint a);
      if (e != a) begin
         $error("%s mismatch: expected %0d actual %0d", name, e, a);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type e, a;
      if (reset) begin
         cam_x = 16'd0;
         cam_y = 16'd0;
         dir_x = 16'd16384;
         dir_y = 16'd0;
         plane_x = 16'd0;
         plane_y = 16'd10813;
         scr_w = 12'd640;
         scr_h = 12'd480;
         loaded = 0;
         projected_q.delete();
         fail_count = 0;
         results_seen = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.payload.reg_index)
               CSR_CAM_X:   cam_x   = csr_mon.payload.wr_data;
               CSR_CAM_Y:   cam_y   = csr_mon.payload.wr_data;
               CSR_DIR_X:   dir_x   = csr_mon.payload.wr_data;
               CSR_DIR_Y:   dir_y   = csr_mon.payload.wr_data;
               CSR_PLANE_X: plane_x = csr_mon.payload.wr_data;
               CSR_PLANE_Y: plane_y = csr_mon.payload.wr_data;
               CSR_SCR_W:   scr_w   = csr_mon.payload.wr_data[11:0];
               CSR_SCR_H:   scr_h   = csr_mon.payload.wr_data[11:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.payload.cell_valid && loaded < MAX_SPRITES) begin
               cell_rows[loaded] = req_mon.payload.cell_row;
               cell_cols[loaded] = req_mon.payload.cell_col;
               loaded++;
            end
            if (req_mon.payload.frame_last) project_frame();
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            a = rsp_mon.payload;
            results_seen++;
            if (projected_q.size() == 0) begin
               $error("result beat with no sprite expected");
               fail_count++;
            end else begin
               e = projected_q.pop_front();
               check_field("sprite_index", e.sprite_index, a.sprite_index);
               check_field("rank", e.rank, a.rank);
               check_field("depth", e.depth, a.depth);
               check_field("screen_x", e.screen_x, a.screen_x);
               check_field("sprite_size", e.sprite_size, a.sprite_size);
               check_field("draw_start_y", e.draw_start_y, a.draw_start_y);
               check_field("draw_end_y", e.draw_end_y, a.draw_end_y);
               check_field("draw_start_x", e.draw_start_x, a.draw_start_x);
               check_field("draw_end_x", e.draw_end_x, a.draw_end_x);
               check_field("not_drawable", e.not_drawable, a.not_drawable);
               check_field("last", e.last, a.last);
            end
         end
      end
      pending = projected_q.size();
   end

endmodule

FILE: sim/tb_raycaster_sprite_projection_core.sv
// Testbench top for the raycaster sprite projection core: drives cell frames and
// register settings, stalls the result side, and reports the verdict.
// Depends on rcsp_pkg, rcsp_if, the core and rcsp_sprite_checker.
`timescale 1ns / 1ps

module tb_raycaster_sprite_projection_core;
   import rcsp_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int   cycles = 0;
   int   items_sent = 0;
   int   frames_sent = 0;
   int   stall_left = 0;
   int   fail_count, pending, results_seen;

   rcsp_req_if req_if ();
   rcsp_rsp_if rsp_if ();
   rcsp_csr_if csr_if ();

   raycaster_sprite_projection_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   rcsp_sprite_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .csr_mon      (csr_if),
      .fail_count   (fail_count),
      .pending      (pending),
      .results_seen (results_seen)
   );

   always #5 clock = ~clock;

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("raycaster_sprite_projection_core test failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 16) - 1;
         rsp_if.ready = 1'b0;
      end else begin
         rsp_if.ready = 1'b1;
      end
   end

   task automatic send_cell(input int row, input int col, input bit cv, input bit fl);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 16)) begin
            @(negedge clock);
            req_if.valid = 1'b0;
         end
      end
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.payload.cell_row = row[5:0];
      req_if.payload.cell_col = col[5:0];
      req_if.payload.cell_valid = cv;
      req_if.payload.frame_last = fl;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      if (fl) frames_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int data);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.payload.reg_index = idx;
      csr_if.payload.wr_data = data[15:0];
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   function automatic int pick_screen();
      case ($urandom_range(0, 4))
         0: return 1;
         1: return 2048;
         2: return 2047;
         default: return $urandom_range(1, 2048);
      endcase
   endfunction

   function automatic int pick_cam();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 65535;
         2: return $urandom_range(0, 65535);
         default: return $urandom_range(0, 16383);
      endcase
   endfunction

   task automatic random_setting();
      int a, b;
      csr_write(CSR_CAM_X, pick_cam());
      csr_write(CSR_CAM_Y, pick_cam());
      case ($urandom_range(0, 5))
         0: begin
            csr_write(CSR_DIR_X, $urandom_range(0, 65535));
            csr_write(CSR_DIR_Y, $urandom_range(0, 65535));
            csr_write(CSR_PLANE_X, $urandom_range(0, 65535));
            csr_write(CSR_PLANE_Y, $urandom_range(0, 65535));
         end
         1: begin
            csr_write(CSR_DIR_X, -32768);
            csr_write(CSR_DIR_Y, 32767);
            csr_write(CSR_PLANE_X, 32767);
            csr_write(CSR_PLANE_Y, -32768);
         end
         default: begin
            a = $urandom_range(0, 32768) - 16384;
            b = $urandom_range(0, 32768) - 16384;
            csr_write(CSR_DIR_X, a);
            csr_write(CSR_DIR_Y, b);
            csr_write(CSR_PLANE_X, b * 2 / 3);
            csr_write(CSR_PLANE_Y, -a * 2 / 3);
         end
      endcase
      csr_write(CSR_SCR_W, pick_screen());
      csr_write(CSR_SCR_H, pick_screen());
   endtask

   task automatic random_frame();
      int n, row, col;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
      row = $urandom_range(0, 63);
      col = $urandom_range(0, 63);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0)
            send_cell($urandom_range(0, 63), $urandom_range(0, 63), 1'b0, 1'b0);
         if ($urandom_range(0, 5) != 0) begin
            row = $urandom_range(0, 63);
            col = $urandom_range(0, 63);
         end
         send_cell(row, col, 1'b1, 1'b0);
      end
      send_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1), 1'b1);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_cell(0, 0, 1'b1, 1'b0);
      send_cell(63, 63, 1'b1, 1'b0);
      send_cell(5, 7, 1'b0, 1'b0);
      send_cell(0, 63, 1'b1, 1'b0);
      send_cell(63, 0, 1'b1, 1'b0);
      send_cell(31, 32, 1'b1, 1'b1);
      send_cell(0, 0, 1'b0, 1'b1);
      send_cell(3, 3, 1'b1, 1'b0);
      send_cell(3, 3, 1'b1, 1'b0);
      send_cell(5, 5, 1'b1, 1'b0);
      send_cell(42, 21, 1'b0, 1'b1);
      drain();
      csr_write(CSR_CAM_X, 2 * 1024 + 512);
      csr_write(CSR_CAM_Y, 2 * 1024 + 512);
      send_cell(2, 2, 1'b1, 1'b0);
      send_cell(2, 4, 1'b1, 1'b1);
      drain();
      csr_write(CSR_DIR_X, 0);
      csr_write(CSR_DIR_Y, 0);
      csr_write(CSR_PLANE_X, 0);
      csr_write(CSR_PLANE_Y, 0);
      send_cell(9, 9, 1'b1, 1'b0);
      send_cell(1, 8, 1'b1, 1'b1);
      drain();
      csr_write(CSR_DIR_X, 16384);
      csr_write(CSR_PLANE_Y, 10813);
      csr_write(CSR_SCR_W, 0);
      csr_write(CSR_SCR_H, 0);
      send_cell(9, 9, 1'b1, 1'b0);
      send_cell(20, 4, 1'b1, 1'b1);
      drain();

      while (items_sent < 520) begin
         random_setting();
         repeat ($urandom_range(1, 4)) begin
            if (items_sent > 460) quiet = 1'b1;
            random_frame();
         end
         drain();
      end

      drain();
      $display("Sent %0d items in %0d frames under many camera and screen settings;",
               items_sent, frames_sent);
      $display("checked %0d projected sprites.", results_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("raycaster_sprite_projection_core test passed");
      end else begin
         $display("raycaster_sprite_projection_core test failed");
      end
      $finish;
   end

endmodule
